// ===== hw/rtl/u2l_pkg.sv =====
`default_nettype none
package u2l_pkg;

  // widths of the fields and registers
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CntW      = 3;  // results per item, 0 to 4
  localparam int unsigned IdxW      = 2;  // word index inside one run
  localparam int unsigned SeenW     = 2;  // continuation bytes held
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned RunDepthDefault = 4;

  // register map, byte addresses divided by four
  localparam logic [0:0] RegReplacement = 1'b0;

  localparam logic [ByteW-1:0] ReplacementReset = 8'h3F;

  // one queued run of results: all words carry the replacement byte but the last
  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [ByteW-1:0] last_char;
    logic             end_of_text;
  } run_t;

  // continuation bytes that a lead asks for, zero when it is no lead
  function automatic logic [1:0] needed_cont(input logic [ByteW-1:0] lead);
    logic [1:0] need;
    need = 2'd0;
    if ((lead & 8'hE0) == 8'hC0) begin
      need = 2'd1;
    end else if ((lead & 8'hF0) == 8'hE0) begin
      need = 2'd2;
    end else if ((lead & 8'hF8) == 8'hF0) begin
      need = 2'd3;
    end
    return need;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/u2l_stream_if.sv =====
`default_nettype none
interface u2l_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_end_of_text;

  modport source (output valid, output in_byte, output in_end_of_text, input ready);
  modport sink   (input valid, input in_byte, input in_end_of_text, output ready);
endinterface

interface u2l_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last_of_run;
  logic       out_end_of_text;

  modport source (output valid, output out_char, output out_last_of_run,
                  output out_end_of_text, input ready);
  modport sink   (input valid, input out_char, input out_last_of_run,
                  input out_end_of_text, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/utf8_to_latin1_transcoder_unit.sv =====
`default_nettype none
// utf-8 to latin-1 transcoder: takes one utf-8 byte per word on in_i and
// gives one latin-1 byte per decoded character on out_o. each input word is
// decoded in the cycle it is accepted, so a new word can be taken every cycle;
// the zero to four result words it causes are queued as one run entry in a
// small run queue (RunDepth entries) and played out one word per cycle while
// out_o.ready is high. in_i.ready only falls when that queue is full, which
// happens when runs pile up faster than the sink drains them, as with runs of
// several replacement bytes (a broken sequence) or a stalling sink.
// the replacement byte sits at apb byte address 0 and resets to '?'; it may
// only be changed while the unit holds no queued results.
module utf8_to_latin1_transcoder_unit #(
  parameter int unsigned RunDepth = u2l_pkg::RunDepthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  u2l_in_if.sink                              in_i,
  u2l_out_if.source                           out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [u2l_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [u2l_pkg::ApbDataW-1:0]   pwdata,
  output logic      [u2l_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready
);
  import u2l_pkg::*;

  localparam int unsigned PtrW  = (RunDepth > 1) ? $clog2(RunDepth) : 1;
  localparam int unsigned FillW = $clog2(RunDepth + 1);
  localparam logic [PtrW-1:0]  LastPtr  = PtrW'(RunDepth - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(RunDepth);

  // configuration register
  logic [ByteW-1:0] repl_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegReplacement);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= ReplacementReset;
    end else if (cfg_wr) begin
      repl_q <= pwdata[ByteW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegReplacement) begin
      prdata = {{(ApbDataW-ByteW){1'b0}}, repl_q};
    end
  end

  // decoder state
  logic [ByteW-1:0] lead_q, lead_d;
  logic             active_q, active_d;
  logic [SeenW-1:0] seen_q, seen_d;

  logic             accept;
  logic [ByteW-1:0] in_b;
  logic             eot;
  logic             is_cont;
  logic [1:0]       need_pend;
  logic [1:0]       need_in;
  logic [CntW-1:0]  flush_n;
  logic [CntW-1:0]  seen_next;
  run_t             run_d;

  assign in_b    = in_i.in_byte;
  assign eot     = in_i.in_end_of_text;
  assign is_cont = (in_b[7:6] == 2'b10);
  assign need_pend = needed_cont(lead_q);
  assign need_in   = needed_cont(in_b);
  assign seen_next = CntW'(seen_q) + CntW'(1);
  // an open sequence that breaks or ends gives one replacement per held byte
  assign flush_n   = active_q ? seen_next : '0;

  always_comb begin
    lead_d          = lead_q;
    active_d        = active_q;
    seen_d          = seen_q;
    run_d.count     = '0;
    run_d.last_char = repl_q;
    run_d.end_of_text = eot;

    if (active_q && is_cont) begin
      if (seen_next >= CntW'(need_pend)) begin
        // sequence complete, only two-byte ones can land inside latin-1
        run_d.count = CntW'(1);
        if (need_pend == 2'd1 && lead_q[4:2] == 3'b000) begin
          run_d.last_char = {lead_q[1:0], in_b[5:0]};
        end
        active_d = 1'b0;
        lead_d   = '0;
        seen_d   = '0;
      end else begin
        seen_d = seen_next[SeenW-1:0];
        if (eot) begin
          // unfinished at end of text: lead plus every held continuation
          run_d.count = seen_next + CntW'(1);
          active_d    = 1'b0;
          lead_d      = '0;
          seen_d      = '0;
        end
      end
    end else begin
      // flush any broken sequence, then treat the byte as fresh
      active_d = 1'b0;
      lead_d   = '0;
      seen_d   = '0;
      if (!in_b[7]) begin
        run_d.count     = flush_n + CntW'(1);
        run_d.last_char = in_b;
      end else if (need_in != 2'd0) begin
        if (eot) begin
          run_d.count = flush_n + CntW'(1);
        end else begin
          run_d.count = flush_n;
          active_d    = 1'b1;
          lead_d      = in_b;
        end
      end else begin
        run_d.count = flush_n + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q   <= '0;
      active_q <= 1'b0;
      seen_q   <= '0;
    end else if (accept) begin
      lead_q   <= lead_d;
      active_q <= active_d;
      seen_q   <= seen_d;
    end
  end

  // run queue
  run_t             run_q [RunDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic [IdxW-1:0]  idx_q;
  logic             push, pop, word_done, is_last;
  run_t             head;

  assign in_i.ready = (fill_q != FullFill);
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && (run_d.count != '0);

  assign head      = run_q[rd_ptr_q];
  assign is_last   = (CntW'(idx_q) == head.count - CntW'(1));
  assign word_done = out_o.valid && out_o.ready;
  assign pop       = word_done && is_last;

  assign out_o.valid           = (fill_q != '0);
  assign out_o.out_char        = is_last ? head.last_char : repl_q;
  assign out_o.out_last_of_run = is_last;
  assign out_o.out_end_of_text = is_last && head.end_of_text;

  always_ff @(posedge clk_i) begin
    if (push) begin
      run_q[wr_ptr_q] <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
      idx_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
        idx_q    <= '0;
      end else if (word_done) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + FillW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_utf8_to_latin1_transcoder_unit.sv =====
`default_nettype none
module tb_utf8_to_latin1_transcoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import u2l_pkg::*;

  // one expected latin-1 word as it should leave out_o
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             last_of_run;
    logic             end_of_text;
  } latin_word_t;

  // lead byte classes, by the number of continuation bytes they ask for
  typedef enum logic [1:0] {
    LeadNone  = 2'd0,
    LeadTwo   = 2'd1,
    LeadThree = 2'd2,
    LeadFour  = 2'd3
  } lead_class_e;

  // limit on the length of the run, ample for a correct one
  localparam int unsigned CycleLimit = 400000;
  // replacement byte register, byte address 4 * index
  localparam logic [ApbAddrW-1:0] ReplAddr = {RegReplacement, 2'b00};
  // cycles allowed after the last result before the unit counts as idle
  localparam int unsigned SettleCycles = 8;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  u2l_in_if  in_bus ();
  u2l_out_if out_bus ();

  utf8_to_latin1_transcoder_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // decoder state of the prediction, kept apart from the unit
  logic [ByteW-1:0] dec_lead;
  logic             dec_open;
  logic [SeenW-1:0] dec_held;
  logic [ByteW-1:0] dec_repl;

  // latin-1 words still owed by the unit, oldest first
  latin_word_t expected_latin[$];
  // characters produced by the word being decoded
  logic [ByteW-1:0] run_chars[$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned words_sent;

  // idling controls, changed by the tests
  bit sender_may_idle;
  bit sink_may_stall;
  int unsigned sink_hold;

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // run limit: a hang anywhere ends here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // prints one line per mismatch and counts it
  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  // continuation bytes a lead asks for
  function automatic lead_class_e lead_class(input logic [ByteW-1:0] b);
    casez (b)
      8'b110?_????: return LeadTwo;
      8'b1110_????: return LeadThree;
      8'b1111_0???: return LeadFour;
      default:      return LeadNone;
    endcase
  endfunction

  // open sequence broken or cut at the end: one replacement per byte held
  task automatic flush_open_sequence();
    if (dec_open) begin
      run_chars.push_back(dec_repl);
      for (int i = 0; i < int'(dec_held); i++) begin
        run_chars.push_back(dec_repl);
      end
      dec_open = 1'b0;
      dec_lead = '0;
      dec_held = '0;
    end
  endtask

  // byte handled with no sequence open
  task automatic take_fresh_byte(input logic [ByteW-1:0] b);
    if (!b[7]) begin
      run_chars.push_back(b);
    end else if (lead_class(b) != LeadNone) begin
      dec_lead = b;
      dec_open = 1'b1;
      dec_held = '0;
    end else begin
      run_chars.push_back(dec_repl);
    end
  endtask

  // works out the latin-1 words that one accepted utf-8 word causes
  task automatic predict_transcode(input logic [ByteW-1:0] b, input logic eot);
    logic [1:0]  need;
    logic [10:0] code_point;
    int          n;
    run_chars = {};
    if (dec_open && b[7:6] == 2'b10) begin
      need = lead_class(dec_lead);
      if ({1'b0, dec_held} + 3'd1 >= {1'b0, need}) begin
        if (need == LeadTwo) begin
          // two-byte form, overlong leads included, fits when below 0x100
          code_point = {dec_lead[4:0], b[5:0]};
          run_chars.push_back(code_point[10:8] == 3'd0 ? code_point[7:0] : dec_repl);
        end else begin
          run_chars.push_back(dec_repl);
        end
        dec_open = 1'b0;
        dec_lead = '0;
        dec_held = '0;
      end else begin
        dec_held = dec_held + 1'b1;
      end
    end else begin
      flush_open_sequence();
      take_fresh_byte(b);
    end
    if (eot) begin
      flush_open_sequence();
    end
    n = run_chars.size();
    for (int i = 0; i < n; i++) begin
      expected_latin.push_back('{ch: run_chars[i], last_of_run: (i == n - 1),
                                 end_of_text: eot && (i == n - 1)});
    end
  endtask

  // result checker: every word taken from out_o against the oldest expectation
  always @(posedge clk_i) begin
    latin_word_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_latin.size() == 0) begin
        report_mismatch("unexpected word, char", out_bus.out_char, 0);
      end else begin
        want = expected_latin.pop_front();
        if (out_bus.out_char !== want.ch) begin
          report_mismatch("out_char", out_bus.out_char, want.ch);
        end
        if (out_bus.out_last_of_run !== want.last_of_run) begin
          report_mismatch("out_last_of_run", out_bus.out_last_of_run, want.last_of_run);
        end
        if (out_bus.out_end_of_text !== want.end_of_text) begin
          report_mismatch("out_end_of_text", out_bus.out_end_of_text, want.end_of_text);
        end
      end
    end
  end

  // sink side: ready drops in bursts of random length while stalls are on
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      out_bus.ready = 1'b0;
      sink_hold--;
    end else begin
      out_bus.ready = 1'b1;
      if (sink_may_stall && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(1, 11);
      end
    end
  end

  // sends one utf-8 word, with an optional gap before it, and predicts on acceptance
  task automatic send_word(input logic [ByteW-1:0] b, input logic eot);
    if (sender_may_idle && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 11)) @(negedge clk_i) in_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid          = 1'b1;
    in_bus.in_byte        = b;
    in_bus.in_end_of_text = eot;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_transcode(b, eot);
    words_sent++;
  endtask

  // stop sending and wait until every expected word has come, then settle
  task automatic drain_results();
    @(negedge clk_i) in_bus.valid = 1'b0;
    while (expected_latin.size() != 0) @(posedge clk_i);
    // a lead word causes no result, so give the unit time to finish
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access until pready
  task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i) penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // apb read of the replacement byte, checked against the prediction
  task automatic check_replacement_reg();
    logic [ApbDataW-1:0] got;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ReplAddr;
    @(negedge clk_i) penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== ApbDataW'(dec_repl)) begin
      report_mismatch("replacement_byte readback", got, dec_repl);
    end
  endtask

  // only written once the unit holds nothing
  task automatic set_replacement(input logic [ByteW-1:0] value);
    drain_results();
    apb_write(ReplAddr, ApbDataW'(value));
    dec_repl = value;
    check_replacement_reg();
  endtask

  function automatic logic random_eot();
    return $urandom_range(0, 15) == 0;
  endfunction

  function automatic logic [ByteW-1:0] random_lead(input lead_class_e cls);
    case (cls)
      LeadTwo:   return ByteW'($urandom_range(8'hC0, 8'hDF));
      LeadThree: return ByteW'($urandom_range(8'hE0, 8'hEF));
      default:   return ByteW'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  // a lead followed by some random continuation bytes
  task automatic send_sequence(input lead_class_e cls, input int unsigned n_cont);
    send_word(random_lead(cls), random_eot());
    repeat (n_cont) send_word(8'h80 | ByteW'($urandom_range(0, 63)), random_eot());
  endtask

  // one random character: mostly well formed, some cut short, some noise
  task automatic send_random_char();
    lead_class_e cls;
    case ($urandom_range(0, 9))
      0, 1, 2: send_word(ByteW'($urandom_range(0, 127)), random_eot());
      3, 4:    send_sequence(LeadTwo, 1);
      5:       send_sequence(LeadThree, 2);
      6:       send_sequence(LeadFour, 3);
      7: begin
        // truncated sequence: the next character breaks it
        cls = lead_class_e'($urandom_range(1, 3));
        send_sequence(cls, $urandom_range(0, int'(cls) - 1));
      end
      8:       send_word(ByteW'($urandom_range(0, 255)), random_eot());
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          send_word(ByteW'($urandom_range(8'h80, 8'hBF)), random_eot());
        end else begin
          send_word(ByteW'($urandom_range(8'hF8, 8'hFF)), random_eot());
        end
      end
    endcase
  endtask

  // register after reset
  task automatic test_register_reset();
    check_replacement_reg();
  endtask

  // ascii and the zero byte pass through, zero does not end the text
  task automatic test_ascii_and_zero();
    send_word(8'h00, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'h7F, 1'b1);
  endtask

  // two-byte forms: in range, overlong leads, and above latin-1
  task automatic test_two_byte();
    send_word(8'hC3, 1'b0);
    send_word(8'hA9, 1'b0);
    send_word(8'hC0, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hC3, 1'b0);
    send_word(8'hBF, 1'b0);
    send_word(8'hC4, 1'b0);
    send_word(8'h80, 1'b0);
  endtask

  // complete three and four byte sequences give one replacement each
  task automatic test_long_sequences();
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'hAC, 1'b0);
    send_word(8'hF0, 1'b0);
    send_word(8'h9F, 1'b0);
    send_word(8'h98, 1'b0);
    send_word(8'h80, 1'b0);
  endtask

  // stray continuation, invalid high lead, and a sequence broken by ascii
  task automatic test_broken_and_stray();
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b0);
    send_word(8'h41, 1'b0);
  endtask

  // end mark on unfinished sequences, up to four words from one byte
  task automatic test_end_of_text();
    send_word(8'hC3, 1'b1);
    send_word(8'hF0, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hC3, 1'b1);
  endtask

  // replacement byte at its extremes and at a random value, each used on a broken sequence
  task automatic test_replacement_config();
    set_replacement(8'h00);
    send_word(8'hE2, 1'b0);
    send_word(8'hFE, 1'b1);
    set_replacement(8'hFF);
    send_word(8'hF4, 1'b0);
    send_word(8'h8F, 1'b0);
    send_word(8'hBF, 1'b1);
    set_replacement(ByteW'($urandom_range(0, 255)));
    send_word(8'hBF, 1'b0);
  endtask

  // random text in segments, idling re-rolled per segment, calm at the end when calm_tail is set
  task automatic test_random_text(input int unsigned n_words, input bit calm_tail);
    int unsigned target;
    int unsigned next_roll;
    target    = words_sent + n_words;
    next_roll = words_sent;
    while (words_sent < target) begin
      if (words_sent >= next_roll) begin
        next_roll       = words_sent + 40;
        sender_may_idle = $urandom_range(0, 2) != 0;
        sink_may_stall  = $urandom_range(0, 2) != 0;
        if (calm_tail && words_sent + 50 >= target) begin
          sender_may_idle = 1'b0;
          sink_may_stall  = 1'b0;
        end
      end
      send_random_char();
    end
  endtask

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_bus.valid          = 1'b0;
    in_bus.in_byte        = '0;
    in_bus.in_end_of_text = 1'b0;
    out_bus.ready         = 1'b0;
    sink_hold             = 0;
    sender_may_idle       = 1'b1;
    sink_may_stall        = 1'b1;
    error_count           = 0;
    cycle_count           = 0;
    words_sent            = 0;
    dec_lead              = '0;
    dec_open              = 1'b0;
    dec_held              = '0;
    dec_repl              = ReplacementReset;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    test_register_reset();
    test_ascii_and_zero();
    test_two_byte();
    test_long_sequences();
    test_broken_and_stray();
    test_end_of_text();
    test_replacement_config();

    test_random_text(120, 1'b0);
    // sender holds off until the unit has delivered everything
    drain_results();
    test_random_text(110, 1'b0);
    set_replacement(ByteW'($urandom_range(0, 255)));
    test_random_text(120, 1'b1);
    set_replacement(ReplacementReset);
    send_word(8'hC3, 1'b1);

    // no more stimulus: wait for the tail, then a little longer
    sink_may_stall = 1'b0;
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
